@@ src/vwe_pkg.sv @@
// Package for the vocabulary word encoder: operation codes, byte constants
// and the letter mapping functions. No dependencies.
package vwe_pkg;

  typedef enum logic [1:0] {
    OpChar     = 2'd0,
    OpEndWord  = 2'd1,
    OpEndTable = 2'd2
  } op_e;

  localparam int unsigned DefaultWordLength = 5;
  localparam int unsigned QueueDepth        = 2;

  localparam logic [7:0] ObfuscateMask = 8'hFF;
  localparam logic [7:0] LeadByte      = 8'd195;
  localparam logic [7:0] DroppedByte   = 8'd128;
  localparam logic [7:0] SpaceCode     = 8'h20;
  localparam logic [7:0] CaseOffset    = 8'd32;
  localparam logic [7:0] Terminator    = 8'd0;
  localparam logic [7:0] NoCode        = 8'd0;

  function automatic logic [7:0] spanish_code(logic [7:0] b);
    logic [7:0] code;
    case (b)
      8'd161, 8'd129: code = 8'd21;
      8'd169, 8'd137: code = 8'd22;
      8'd173, 8'd141: code = 8'd23;
      8'd179, 8'd147: code = 8'd24;
      8'd186, 8'd154: code = 8'd25;
      8'd145, 8'd177: code = 8'd27;
      8'd135, 8'd167: code = 8'd29;
      8'd156, 8'd188: code = 8'd31;
      default:        code = NoCode;
    endcase
    return code;
  endfunction

  function automatic logic [7:0] encode_letter(logic [7:0] ch);
    logic [7:0] up;
    up = ch;
    if (ch inside {[8'h61:8'h7A]}) begin
      up = ch - CaseOffset;
    end
    return up ^ ObfuscateMask;
  endfunction

endpackage

@@ src/vwe_queue.sv @@
// Short register queue between the front and the back of the encoder.
// Depends on nothing but its parameters.
module vwe_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [Width-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [Width-1:0] pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ src/vwe_front.sv @@
// Front of the encoder: accepts items, decodes two-byte letters, buffers the
// kept codes and queues one job per word or table end. Uses vwe_pkg.
module vwe_front import vwe_pkg::*; #(
  parameter int unsigned WordLength = DefaultWordLength,
  parameter int unsigned JobW       = WordLength * 8 + 17
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      operation_i,
  input  logic [7:0]      char_byte_i,
  input  logic [7:0]      word_value_i,
  input  logic [7:0]      word_type_i,
  output logic            job_valid_o,
  input  logic            job_ready_i,
  output logic [JobW-1:0] job_data_o
);

  localparam int unsigned CntW = $clog2(WordLength + 1);
  localparam int unsigned IdxW = (WordLength > 1) ? $clog2(WordLength) : 1;

  logic [7:0]      buf_q [WordLength];
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pend_q, pend_d;
  logic            keep;
  logic [7:0]      keep_code, mapped;
  logic            is_job, is_table, accept;
  logic [WordLength*8-1:0] letters;

  always_comb begin
    is_job   = 1'b0;
    is_table = 1'b0;
    case (op_e'(operation_i))
      OpEndWord:  is_job = 1'b1;
      OpEndTable: begin
        is_job   = 1'b1;
        is_table = 1'b1;
      end
      default: ;
    endcase
  end

  assign in_ready_o  = !is_job || job_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign job_valid_o = in_valid_i && is_job;
  assign mapped      = spanish_code(char_byte_i);

  always_comb begin
    for (int j = 0; j < WordLength; j++) begin
      letters[8*j +: 8] = encode_letter((CntW'(j) < cnt_q) ? buf_q[j] : SpaceCode);
    end
  end

  assign job_data_o = {is_table, word_value_i, word_type_i, letters};

  always_comb begin
    cnt_d     = cnt_q;
    pend_d    = pend_q;
    keep      = 1'b0;
    keep_code = char_byte_i;
    if (accept) begin
      case (op_e'(operation_i))
        OpChar: begin
          if (pend_q) begin
            pend_d    = 1'b0;
            keep_code = mapped;
            keep      = (mapped != NoCode);
          end else if (char_byte_i == LeadByte) begin
            pend_d = 1'b1;
          end else if (char_byte_i != DroppedByte) begin
            keep = 1'b1;
          end
        end
        OpEndWord, OpEndTable: begin
          cnt_d  = '0;
          pend_d = 1'b0;
        end
        default: ;
      endcase
    end
    if (keep && (cnt_q < CntW'(WordLength))) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (keep && (cnt_q < CntW'(WordLength))) begin
      buf_q[cnt_q[IdxW-1:0]] <= keep_code;
    end
  end

endmodule

@@ src/vwe_back.sv @@
// Back of the encoder: emits the bytes of queued jobs one per cycle unless the
// receiver stalls, via an output register, each with its address. Uses vwe_pkg.
module vwe_back import vwe_pkg::*; #(
  parameter int unsigned WordLength = DefaultWordLength,
  parameter int unsigned JobW       = WordLength * 8 + 17
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [15:0]     start_address_i,
  input  logic            job_valid_i,
  output logic            job_ready_o,
  input  logic [JobW-1:0] job_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic [15:0]     out_address_o,
  output logic            last_of_run_o
);

  localparam int unsigned PosW = $clog2(WordLength + 2);
  localparam int unsigned LetW = WordLength * 8;

  logic [JobW-1:0] job_q, job_d;
  logic            cur_valid_q, cur_valid_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_byte_q;
  logic [15:0]     addr_q, addr_d, out_addr_q;
  logic            out_last_q;
  logic [7:0]      byte_c, letter;
  logic            last_c, emit, finish, pop;

  always_comb begin
    letter = SpaceCode;
    for (int j = 0; j < WordLength; j++) begin
      if (pos_q == PosW'(j)) begin
        letter = job_q[8*j +: 8];
      end
    end
  end

  always_comb begin
    last_c = 1'b0;
    if (job_q[JobW-1]) begin
      byte_c = Terminator;
      last_c = 1'b1;
    end else if (pos_q < PosW'(WordLength)) begin
      byte_c = letter;
    end else if (pos_q == PosW'(WordLength)) begin
      byte_c = job_q[LetW+8 +: 8];
    end else begin
      byte_c = job_q[LetW +: 8];
      last_c = 1'b1;
    end
  end

  assign emit        = cur_valid_q && (!out_valid_q || out_ready_i);
  assign finish      = emit && last_c;
  assign job_ready_o = !cur_valid_q || finish;
  assign pop         = job_ready_o && job_valid_i;

  always_comb begin
    job_d       = pop ? job_data_i : job_q;
    cur_valid_d = pop ? 1'b1 : (finish ? 1'b0 : cur_valid_q);
    pos_d       = pop ? '0 : (emit ? pos_q + 1'b1 : pos_q);
    out_valid_d = emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
    addr_d      = cfg_we_i ? start_address_i : (emit ? addr_q + 16'd1 : addr_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
      addr_q      <= '0;
    end else begin
      cur_valid_q <= cur_valid_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
      addr_q      <= addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    if (emit) begin
      out_byte_q <= byte_c;
      out_addr_q <= addr_q;
      out_last_q <= last_c;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign out_address_o = out_addr_q;
  assign last_of_run_o = out_last_q;

endmodule

@@ src/vocabulary_word_encoder.sv @@
// Top level of the vocabulary word encoder: front, job queue and back.
// Depends on vwe_pkg, vwe_front, vwe_queue and vwe_back.
//
// Usage: the input channel takes one item per cycle while it is ready (end
// items wait while the job queue is full): a word character byte, an end of
// word with value and type bytes, or an end of table. Character items produce
// no result and are taken every cycle. An end of word produces WORD_LENGTH
// letter bytes, then the value byte and the type byte; an end of table
// produces a single 0. Each result carries its 16-bit address and a last flag
// on the final byte of the item.
// An end item's first byte passes through the queue, the back's job register
// and the output register. The back emits one byte per cycle while the
// receiver is ready; a word is WORD_LENGTH+2 bytes at the output.
// The job queue holds two pending jobs, so the front keeps accepting
// characters while the back drains; when the receiver stalls, the output
// holds and end items wait once the queue is full.
// Reset clears the buffer count, the pending lead flag, the queue and the
// address (to 0). A write of start_address loads the address of the next byte.
module vocabulary_word_encoder import vwe_pkg::*; #(
  parameter int unsigned WordLength = DefaultWordLength
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] start_address_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  char_byte_i,
  input  logic [7:0]  word_value_i,
  input  logic [7:0]  word_type_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic [15:0] out_address_o,
  output logic        last_of_run_o
);

  localparam int unsigned JobW = WordLength * 8 + 17;

  logic            fq_valid, fq_ready, qb_valid, qb_ready;
  logic [JobW-1:0] fq_data, qb_data;

  vwe_front #(
    .WordLength(WordLength),
    .JobW      (JobW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .char_byte_i (char_byte_i),
    .word_value_i(word_value_i),
    .word_type_i (word_type_i),
    .job_valid_o (fq_valid),
    .job_ready_i (fq_ready),
    .job_data_o  (fq_data)
  );

  vwe_queue #(
    .Width(JobW),
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(fq_valid),
    .push_ready_o(fq_ready),
    .push_data_i (fq_data),
    .pop_valid_o (qb_valid),
    .pop_ready_i (qb_ready),
    .pop_data_o  (qb_data)
  );

  vwe_back #(
    .WordLength(WordLength),
    .JobW      (JobW)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .start_address_i(start_address_i),
    .job_valid_i    (qb_valid),
    .job_ready_o    (qb_ready),
    .job_data_i     (qb_data),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .out_address_o  (out_address_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule
